>>> hdl/bcdds_pkg.sv
// Shared constants for the BCD digit scan driver.
package bcdds_pkg;

   // Width of one BCD digit and of the bits shifted into the cell row per cycle.
   localparam int BCD_BITS  = 4;
   localparam int STEP_BITS = 4;

   // Output position select width and digit count register width.
   localparam int SEL_BITS = 3;
   localparam int CSR_BITS = 4;

   // Parameter defaults.
   localparam int DEFAULT_MAX_DIGITS = 8;
   localparam int DEFAULT_VALUE_BITS = 32;

   // Digit count after reset.
   localparam logic [CSR_BITS-1:0] DIGIT_COUNT_RESET = 4'd3;

   // Digit correction threshold and offset for the shift-and-add-3 step.
   localparam logic [BCD_BITS-1:0] ADJ_LIMIT  = 4'd5;
   localparam logic [BCD_BITS-1:0] ADJ_OFFSET = 4'd3;

   // Handshake between the converter and the scanner.
   typedef struct packed {
      logic done;
      logic take;
   } handoff_type;

endpackage

>>> hdl/bcdds_cell.sv
// One BCD digit cell of the shift-and-add-3 conversion row.
module bcdds_cell (
   input  logic                            clock,
   input  logic                            load,
   input  logic                            step,
   input  logic [bcdds_pkg::STEP_BITS-1:0] carry_in,
   output logic [bcdds_pkg::STEP_BITS-1:0] carry_out,
   output logic [bcdds_pkg::BCD_BITS-1:0]  digit
);
   import bcdds_pkg::*;

   logic [BCD_BITS-1:0] digit_ff;
   logic [BCD_BITS-1:0] digit_in;

   // Run the correct-then-double step once per incoming bit, most significant first.
   // The bit shifted out of each step goes to the next cell up in the same step.
   always_comb begin
      logic [BCD_BITS-1:0] cur;
      logic [BCD_BITS-1:0] adj;
      cur = load ? '0 : digit_ff;
      carry_out = '0;
      for (int j = STEP_BITS - 1; j >= 0; j--) begin
         adj = (cur >= ADJ_LIMIT) ? cur + ADJ_OFFSET : cur;
         carry_out[j] = adj[BCD_BITS-1];
         cur = {adj[BCD_BITS-2:0], carry_in[j]};
      end
      digit_in = cur;
   end

   // The digit register advances on the first step and on every later step.
   always_ff @(posedge clock) begin
      if (load || step) begin
         digit_ff <= digit_in;
      end
   end

   assign digit = digit_ff;

endmodule

>>> hdl/bcdds_conv.sv
// Binary to BCD converter: a row of digit cells fed four bits per cycle.
module bcdds_conv #(
   parameter int MAX_DIGITS = bcdds_pkg::DEFAULT_MAX_DIGITS,
   parameter int VALUE_BITS = bcdds_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [VALUE_BITS-1:0]                    req_value,
   output logic [MAX_DIGITS*bcdds_pkg::BCD_BITS-1:0] digits,
   output logic                                     done,
   input  logic                                     take
);
   import bcdds_pkg::*;

   localparam int NSTEP = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int PAD   = NSTEP * STEP_BITS;
   localparam int CW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;

   logic            full_ff, full_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [PAD-1:0]  shift_ff, shift_in;
   logic [PAD-1:0]  padded;
   logic            busy, accept;
   logic [STEP_BITS-1:0] step_bits;
   logic [STEP_BITS-1:0] chain [MAX_DIGITS];

   // Control: a request is taken when the row is empty or its result leaves now.
   assign padded    = PAD'(req_value);
   assign busy      = full_ff && (cnt_ff != '0);
   assign done      = full_ff && (cnt_ff == '0);
   assign req_ready = !full_ff || (done && take);
   assign accept    = req_valid && req_ready;
   assign step_bits = accept ? padded[PAD-1 -: STEP_BITS] : shift_ff[PAD-1 -: STEP_BITS];
   assign chain[0]  = step_bits;

   always_comb begin
      full_in  = full_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      if (accept) begin
         full_in  = 1'b1;
         cnt_in   = CW'(NSTEP - 1);
         shift_in = padded << STEP_BITS;
      end else if (done && take) begin
         full_in = 1'b0;
      end else if (busy) begin
         cnt_in   = cnt_ff - 1'b1;
         shift_in = shift_ff << STEP_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         full_ff <= full_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
   end

   // Row of digit cells, least significant at index 0.
   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
      if (i < MAX_DIGITS - 1) begin : g_mid
         bcdds_cell u_cell (
            .clock     (clock),
            .load      (accept),
            .step      (busy),
            .carry_in  (chain[i]),
            .carry_out (chain[i+1]),
            .digit     (digits[i*BCD_BITS +: BCD_BITS])
         );
      end else begin : g_top
         // Carries out of the top cell are beyond the display and dropped.
         bcdds_cell u_cell (
            .clock     (clock),
            .load      (accept),
            .step      (busy),
            .carry_in  (chain[i]),
            .carry_out (),
            .digit     (digits[i*BCD_BITS +: BCD_BITS])
         );
      end
   end

endmodule

>>> hdl/bcdds_scan.sv
// Digit scanner: shifts out one converted digit per response.
module bcdds_scan #(
   parameter int MAX_DIGITS = bcdds_pkg::DEFAULT_MAX_DIGITS
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic [bcdds_pkg::CSR_BITS-1:0]            digit_count,
   input  logic [MAX_DIGITS*bcdds_pkg::BCD_BITS-1:0] digits,
   input  logic                                      done,
   output logic                                      take,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic [bcdds_pkg::SEL_BITS-1:0]            rsp_digit_select,
   output logic [bcdds_pkg::BCD_BITS-1:0]            rsp_bcd_digit,
   output logic                                      rsp_last
);
   import bcdds_pkg::*;

   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W0 = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int IDX_W  = (IDX_W0 < SEL_BITS) ? SEL_BITS : IDX_W0;
   localparam int DW     = MAX_DIGITS * BCD_BITS;

   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [DW-1:0]    digits_ff, digits_in;
   logic [CNT_W-1:0] n_eff;
   logic             fire;

   // Digit count saturates at the number of cells.
   assign n_eff = (digit_count > CSR_BITS'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS)
                                                        : CNT_W'(digit_count);

   // A new result is taken when the scanner is empty or sends its last digit now.
   assign rsp_valid = (rem_ff != '0);
   assign fire      = rsp_valid && rsp_ready;
   assign take      = !rsp_valid || (fire && (rem_ff == CNT_W'(1)));

   always_comb begin
      rem_in    = rem_ff;
      idx_in    = idx_ff;
      digits_in = digits_ff;
      if (done && take) begin
         rem_in    = n_eff;
         idx_in    = '0;
         digits_in = digits;
      end else if (fire) begin
         rem_in    = rem_ff - 1'b1;
         idx_in    = idx_ff + 1'b1;
         digits_in = digits_ff >> BCD_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
      idx_ff    <= idx_in;
      digits_ff <= digits_in;
   end

   // Response fields.
   assign rsp_digit_select = idx_ff[SEL_BITS-1:0];
   assign rsp_bcd_digit    = digits_ff[BCD_BITS-1:0];
   assign rsp_last         = (rem_ff == CNT_W'(1));

endmodule

>>> hdl/bcd_digit_scan_driver.sv
// Top level of the BCD digit scan driver.
//
// Each request carries one unsigned binary value on req_value. The block
// converts it to decimal and returns one response per digit, least
// significant first, for the number of digits held in the digit count
// register (saturated at MAX_DIGITS; a count of zero gives no response).
// Each response gives the display position, the BCD code and a last flag.
// Conversion runs in a row of digit cells that take four bits of the value
// per cycle. The first digit appears once every bit has been shifted in and
// the scanner has taken the result. The next request is converted while the
// previous digits are scanned out. When rsp_ready is low the current digit
// holds. req_ready is low while a value is converted and stays low until
// the scanner takes it.
// Synchronous reset empties both stages and sets the digit count to 3.
// csr_write_enable writes csr_write_data into the digit count at once.
module bcd_digit_scan_driver #(
   parameter int MAX_DIGITS = bcdds_pkg::DEFAULT_MAX_DIGITS,
   parameter int VALUE_BITS = bcdds_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [VALUE_BITS-1:0]          req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bcdds_pkg::SEL_BITS-1:0] rsp_digit_select,
   output logic [bcdds_pkg::BCD_BITS-1:0] rsp_bcd_digit,
   output logic                           rsp_last,
   input  logic                           csr_write_enable,
   input  logic [bcdds_pkg::CSR_BITS-1:0] csr_write_data
);
   import bcdds_pkg::*;

   logic [CSR_BITS-1:0]          digit_count_ff;
   logic [MAX_DIGITS*BCD_BITS-1:0] digits;
   handoff_type                  handoff;
   logic                         take;

   // Digit count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff <= DIGIT_COUNT_RESET;
      end else if (csr_write_enable) begin
         digit_count_ff <= csr_write_data;
      end
   end

   // Converter stage.
   bcdds_conv #(
      .MAX_DIGITS (MAX_DIGITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_conv (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_value (req_value),
      .digits    (digits),
      .done      (handoff.done),
      .take      (handoff.take)
   );

   // Scanner stage.
   bcdds_scan #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_scan (
      .clock            (clock),
      .reset            (reset),
      .digit_count      (digit_count_ff),
      .digits           (digits),
      .done             (handoff.done),
      .take             (take),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digit_select (rsp_digit_select),
      .rsp_bcd_digit    (rsp_bcd_digit),
      .rsp_last         (rsp_last)
   );

   assign handoff.take = take;

endmodule

>>> tb/tb_bcd_digit_scan_driver.sv
// Self-checking testbench for the BCD digit scan driver.
module tb_bcd_digit_scan_driver;
   timeunit 1ns;
   timeprecision 1ps;

   import bcdds_pkg::*;

   localparam int VALUE_W     = DEFAULT_VALUE_BITS;
   localparam int DIGITS_MAX  = DEFAULT_MAX_DIGITS;
   localparam int SETTLE      = 24;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 8;
   localparam int IDLE_PCT    = 46;
   localparam int LIGHT_PCT   = 10;

   // Pacing of the two channels within one phase.
   typedef enum int {
      PACE_FULL,
      PACE_SENDER_IDLE,
      PACE_RECEIVER_STALL,
      PACE_BOTH
   } pace_type;

   // One expected digit on the response channel.
   typedef struct packed {
      logic [SEL_BITS-1:0] sel;
      logic [BCD_BITS-1:0] digit;
      logic                last;
   } scan_digit_type;

   // One directed request; bcd holds the typed digits when typed is set.
   typedef struct packed {
      logic [CSR_BITS-1:0] count;
      logic [VALUE_W-1:0]  value;
      logic                typed;
      logic [31:0]         bcd;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 22;
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{4'd3,  32'd0,          1'b1, 32'h0},
      '{4'd3,  32'd999,        1'b1, 32'h999},
      '{4'd3,  32'd1234,       1'b1, 32'h234},
      '{4'd3,  32'd4294967295, 1'b1, 32'h295},
      '{4'd8,  32'd4294967295, 1'b1, 32'h94967295},
      '{4'd8,  32'd12345678,   1'b1, 32'h12345678},
      '{4'd8,  32'd7,          1'b1, 32'h7},
      '{4'd8,  32'd99999999,   1'b1, 32'h99999999},
      '{4'd8,  32'd100000000,  1'b1, 32'h0},
      '{4'd15, 32'd4294967295, 1'b1, 32'h94967295},
      '{4'd9,  32'd123456789,  1'b1, 32'h23456789},
      '{4'd0,  32'd55,         1'b1, 32'h0},
      '{4'd0,  32'd4294967295, 1'b1, 32'h0},
      '{4'd1,  32'd9,          1'b1, 32'h9},
      '{4'd1,  32'd10,         1'b1, 32'h0},
      '{4'd1,  32'h80000001,   1'b0, 32'h0},
      '{4'd4,  32'hAAAA5555,   1'b0, 32'h0},
      '{4'd4,  32'h5555AAAA,   1'b0, 32'h0},
      '{4'd2,  32'd99,         1'b1, 32'h99},
      '{4'd6,  32'd1000000,    1'b1, 32'h0},
      '{4'd6,  32'd999999,     1'b1, 32'h999999},
      '{4'd7,  32'd3141592,    1'b0, 32'h0}
   };

   // Digit counts walked by the random phases; later phases pick at random.
   localparam logic [CSR_BITS-1:0] PHASE_COUNTS [8] = '{
      4'd8, 4'd1, 4'd0, 4'd15, 4'd5, 4'd2, 4'd7, 4'd9
   };

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic [VALUE_W-1:0]  req_value        = '0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic [SEL_BITS-1:0] rsp_digit_select;
   logic [BCD_BITS-1:0] rsp_bcd_digit;
   logic                rsp_last;
   logic                csr_write_enable = 1'b0;
   logic [CSR_BITS-1:0] csr_write_data   = '0;

   scan_digit_type      pending_digits[$];
   logic [CSR_BITS-1:0] digit_count = DIGIT_COUNT_RESET;
   int                  sender_idle_pct = 0;
   int                  stall_pct       = 0;
   int                  errors          = 0;

   bcd_digit_scan_driver u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digit_select (rsp_digit_select),
      .rsp_bcd_digit    (rsp_bcd_digit),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Number of digits scanned for a given count, saturated at the maximum.
   function automatic int scan_length(input logic [CSR_BITS-1:0] count);
      return (count > DIGITS_MAX) ? DIGITS_MAX : int'(count);
   endfunction

   // Splits a value into its low decimal digits and queues one response per digit.
   function automatic void predict_digits(input logic [VALUE_W-1:0] value,
                                          input logic [CSR_BITS-1:0] count);
      logic [VALUE_W-1:0] rest;
      int                 n;
      scan_digit_type     item;
      rest = value;
      n    = scan_length(count);
      for (int d = 0; d < n; d++) begin
         item.sel   = SEL_BITS'(d);
         item.digit = BCD_BITS'(rest % 10);
         item.last  = (d == n - 1);
         rest       = rest / 10;
         pending_digits.push_back(item);
      end
   endfunction

   // Queues digits typed in as packed BCD, least significant nibble first.
   function automatic void queue_typed_digits(input logic [31:0] bcd,
                                              input logic [CSR_BITS-1:0] count);
      int             n;
      scan_digit_type item;
      n = scan_length(count);
      for (int d = 0; d < n; d++) begin
         item.sel   = SEL_BITS'(d);
         item.digit = bcd[4*d +: 4];
         item.last  = (d == n - 1);
         pending_digits.push_back(item);
      end
   endfunction

   // Picks a value from a mix of full-range, short, at most eight-digit and decade-boundary numbers.
   function automatic logic [VALUE_W-1:0] random_value();
      logic [VALUE_W-1:0] decade;
      int                 k;
      decade = 1;
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(999);
         2: begin
            k = $urandom_range(9, 1);
            for (int i = 0; i < k; i++) decade = decade * 10;
            return decade - $urandom_range(1);
         end
         default: return $urandom % 100000000;
      endcase
   endfunction

   // Sets the idling percentages of both channels.
   task automatic set_pace(input pace_type pace);
      case (pace)
         PACE_FULL: begin
            sender_idle_pct = 0;
            stall_pct       = 0;
         end
         PACE_SENDER_IDLE: begin
            sender_idle_pct = IDLE_PCT;
            stall_pct       = 0;
         end
         PACE_RECEIVER_STALL: begin
            sender_idle_pct = 0;
            stall_pct       = IDLE_PCT;
         end
         default: begin
            sender_idle_pct = LIGHT_PCT;
            stall_pct       = LIGHT_PCT;
         end
      endcase
   endtask

   // Drives one request and returns at the edge where it is accepted.
   task automatic send_request(input logic [VALUE_W-1:0] value);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // Holds the sender off until every queued digit has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_digits.size() != 0) @(posedge clock);
   endtask

   // Changes the digit count once the block is idle.
   task automatic write_digit_count(input logic [CSR_BITS-1:0] count);
      wait_for_drain();
      repeat (SETTLE) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= count;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      digit_count = count;
   endtask

   // Response side back-pressure.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Compares each accepted response with the oldest queued digit.
   always @(posedge clock) begin
      scan_digit_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_digits.size() == 0) begin
            $error("unexpected response: digit_select %0d bcd_digit %0d last %0b",
                   rsp_digit_select, rsp_bcd_digit, rsp_last);
            errors++;
         end else begin
            want = pending_digits.pop_front();
            if (rsp_digit_select !== want.sel) begin
               $error("digit_select expected %0d, got %0d", want.sel, rsp_digit_select);
               errors++;
            end
            if (rsp_bcd_digit !== want.digit) begin
               $error("bcd_digit expected %0d, got %0d", want.digit, rsp_bcd_digit);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $error("last expected %0b, got %0b", want.last, rsp_last);
               errors++;
            end
         end
      end
   end

   // Main sequence: reset, directed table, then paced random phases.
   initial begin
      logic [VALUE_W-1:0]  value;
      logic [CSR_BITS-1:0] count;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table; the count is rewritten only where a row changes it.
      set_pace(PACE_FULL);
      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].count != digit_count) write_digit_count(DIRECTED[i].count);
         send_request(DIRECTED[i].value);
         if (DIRECTED[i].typed) queue_typed_digits(DIRECTED[i].bcd, digit_count);
         else predict_digits(DIRECTED[i].value, digit_count);
      end

      // Random phases, each with its own count and pacing.
      for (int p = 0; p < PHASES; p++) begin
         count = (p < 8) ? PHASE_COUNTS[p] : CSR_BITS'($urandom_range(15));
         write_digit_count(count);
         set_pace(pace_type'(p % 4));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Midway through each phase the sender waits for all digits.
            if (i == PHASE_ITEMS / 2) wait_for_drain();
            value = random_value();
            send_request(value);
            predict_digits(value, digit_count);
         end
      end

      wait_for_drain();
      repeat (SETTLE) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2ms;
      $display("Verification failed");
      $finish;
   end

endmodule
